// File: design/kwsm_pkg.sv
`timescale 1ns / 1ps

package kwsm_pkg;

    // Default sizing
    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;

    // Request modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Response status codes
    localparam logic [2:0] ST_POPPED  = 3'd0;
    localparam logic [2:0] ST_LOADED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         list_number;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] merged_value;
        logic [2:0]         source_list;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_WAIT,
        S_POP,
        S_CLEAR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic scan;
        logic pop;
        logic clear;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// File: design/kwsm_ctrl.sv
`timescale 1ns / 1ps

module kwsm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    mode,
    output logic          req_ready,
    input  kwsm_pkg::sts_t sts,
    output kwsm_pkg::cmd_t cmd
);
    import kwsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (mode)
                        MODE_LOAD:  state_next = S_LOAD;
                        MODE_POP:   state_next = S_SCAN;
                        MODE_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_LOAD:  cmd.load  = sts.out_free;
            S_SCAN:  cmd.scan  = 1'b1;
            S_WAIT:  cmd       = '0;
            S_POP:   cmd.pop   = sts.out_free;
            S_CLEAR: cmd.clear = sts.out_free;
            default: cmd       = '0;
        endcase
    end

endmodule

// File: design/kwsm_dp.sv
`timescale 1ns / 1ps

module kwsm_dp #(
    parameter int NUM_LISTS  = kwsm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwsm_pkg::LIST_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kwsm_pkg::req_item_t req_data,
    input  kwsm_pkg::cmd_t      cmd,
    output kwsm_pkg::sts_t      sts,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kwsm_pkg::rsp_item_t rsp_data
);
    import kwsm_pkg::*;

    localparam int LW    = $clog2(NUM_LISTS);
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int PW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int AW    = LW + PW;
    localparam int MDEPTH = NUM_LISTS << PW;

    // Captured request
    logic [2:0]         list_reg;
    logic signed [31:0] value_reg;

    // Per-list counters
    logic [CW-1:0] fill_reg [NUM_LISTS];
    logic [CW-1:0] rp_reg   [NUM_LISTS];

    // Element memory
    logic signed [31:0] mem [MDEPTH];
    logic signed [31:0] rd_data_reg;

    // Scan and compare state
    logic [LW-1:0]      scan_idx_reg;
    logic               cmp_valid_reg;
    logic [LW-1:0]      cmp_list_reg;
    logic [CW-1:0]      cmp_rp_reg;
    logic               found_reg;
    logic [LW-1:0]      best_list_reg;
    logic [CW-1:0]      best_rp_reg;
    logic signed [31:0] best_value_reg;

    // Output register
    logic      rsp_valid_reg;
    rsp_item_t rsp_data_reg;

    logic [LW-1:0] item_lidx;
    logic [LW-1:0] cnt_idx;
    logic [CW-1:0] fill_rd;
    logic [CW-1:0] rp_rd;
    logic          list_ok;
    logic          not_full;
    logic          head_live;
    logic          take_head;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    assign item_lidx = LW'(list_reg);
    assign cnt_idx   = cmd.load ? item_lidx : scan_idx_reg;
    assign fill_rd   = fill_reg[cnt_idx];
    assign rp_rd     = rp_reg[cnt_idx];
    assign list_ok   = {29'd0, list_reg} < 32'(NUM_LISTS);
    assign not_full  = fill_rd < CW'(LIST_DEPTH);
    assign head_live = rp_rd < fill_rd;
    assign waddr     = {item_lidx, PW'(fill_rd)};
    assign raddr     = {scan_idx_reg, PW'(rp_rd)};
    assign take_head = cmp_valid_reg && (!found_reg || (rd_data_reg < best_value_reg));

    assign sts.scan_last = scan_idx_reg == LW'(NUM_LISTS - 1);
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Hold the request fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            list_reg  <= req_data.list_number;
            value_reg <= req_data.value;
        end
    end

    // Write on load, read one head per scan step
    always_ff @(posedge clk)
    begin
        if (cmd.load && list_ok && not_full)
        begin
            mem[waddr] <= value_reg;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Advance fill and read counts, empty all on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.load && list_ok && not_full)
            begin
                fill_reg[item_lidx] <= fill_rd + CW'(1);
            end
            if (cmd.pop && found_reg)
            begin
                rp_reg[best_list_reg] <= best_rp_reg + CW'(1);
            end
        end
    end

    // Step the scan and track the smallest head; ties keep the lower list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan && head_live;
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !sts.scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + LW'(1);
                end
                if (take_head)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Compare stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            cmp_list_reg <= scan_idx_reg;
            cmp_rp_reg   <= rp_rd;
        end
        if (take_head)
        begin
            best_list_reg  <= cmp_list_reg;
            best_rp_reg    <= cmp_rp_reg;
            best_value_reg <= rd_data_reg;
        end
    end

    // Output register: fill on finish, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load || cmd.pop || cmd.clear)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_data_reg.status       <= (list_ok && not_full) ? ST_LOADED : ST_DROPPED;
            rsp_data_reg.merged_value <= '0;
            rsp_data_reg.source_list  <= '0;
        end
        else if (cmd.pop)
        begin
            rsp_data_reg.status       <= found_reg ? ST_POPPED : ST_EMPTY;
            rsp_data_reg.merged_value <= found_reg ? best_value_reg : '0;
            rsp_data_reg.source_list  <= found_reg ? 3'(best_list_reg) : '0;
        end
        else if (cmd.clear)
        begin
            rsp_data_reg.status       <= ST_CLEARED;
            rsp_data_reg.merged_value <= '0;
            rsp_data_reg.source_list  <= '0;
        end
    end

    // Checks
    a_cmp_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> $past(cmd.scan))
        else $error("compare stage loaded without a scan step");

    a_pop_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !cmp_valid_reg)
        else $error("pop finished with a compare still in flight");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load || cmd.pop || cmd.clear))
        else $error("response raised without a finishing command");

    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_chk
        a_rp_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
            (rp_reg[g] <= fill_reg[g]) && (fill_reg[g] <= CW'(LIST_DEPTH)))
            else $error("read position past fill count");
    end

endmodule

// File: design/k_way_sorted_list_merger_top.sv
`timescale 1ns / 1ps

// K-way merger of ascending lists of signed 32-bit values.
// Request channel (req_valid/req_ready/req_data): mode 0 appends value to
// list list_number, mode 1 pops the smallest live head (lower list wins a
// tie), mode 2 empties every list. Mode 3 is taken and discarded.
// Response channel (rsp_valid/rsp_ready/rsp_data): one transfer per load,
// pop or clear, carrying status, merged_value and source_list.
// Load and clear go from acceptance through their own state into the
//   response register; pop goes through the one-head-per-cycle scan over the
//   single read port of the element memory, one shared compare stage, a wait
//   state and the response write.
// A new request is taken once the previous one has been written into the
// response register, so a held response overlaps the next item's work.
// If the receiver stalls, the finished item waits in its final state until
// the response register frees up; nothing is lost or reordered.
// Reset clears all fill and read counts and the response valid flag; the
// element memory is not cleared and needs no sweep.
module k_way_sorted_list_merger_top #(
    parameter int NUM_LISTS  = kwsm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwsm_pkg::LIST_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  kwsm_pkg::req_item_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kwsm_pkg::rsp_item_t rsp_data
);
    import kwsm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kwsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .mode      (req_data.mode),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kwsm_dp #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
